[rtl/core/smq_pkg.sv]
`default_nettype none

package smq_pkg;

    // defaults for the top-level parameters
    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_CHIPS_DEF   = 4;

    // every driver chip shows sixteen bytes
    localparam int BYTES_PER_CHIP = 16;
    localparam int BPC_SHIFT      = 4;

    // field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int BIDX_W     = 6;
    localparam int MS_W       = 16;
    localparam int DIGITS_W   = 6;
    localparam int CHIPS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd2;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_DWELL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOWN_DIGITS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_COUNT   = 3'd6;

    // configuration reset values
    localparam logic                  RST_SCROLL_ENABLE   = 1'b1;
    localparam logic                  RST_CONTINUOUS_MODE = 1'b0;
    localparam logic [MS_W-1:0]       RST_START_DELAY     = 16'd1500;
    localparam logic [MS_W-1:0]       RST_END_DWELL       = 16'd1000;
    localparam logic [MS_W-1:0]       RST_STEP_PERIOD     = 16'd250;
    localparam logic [DIGITS_W-1:0]   RST_SHOWN_DIGITS    = 6'd8;
    localparam logic [CHIPS_W-1:0]    RST_DISPLAY_COUNT   = 3'd1;

endpackage

`default_nettype wire

[rtl/core/smq_ram.sv]
`default_nettype none

module smq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/smq_job_fifo.sv]
`default_nettype none

module smq_job_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/smq_front.sv]
`default_nettype none

module smq_front #(
    parameter int STORE_DEPTH = smq_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHIPS   = smq_pkg::MAX_CHIPS_DEF,
    parameter int LEN_W       = $clog2(STORE_DEPTH + 1),
    parameter int CNT_W       = $clog2(MAX_CHIPS * smq_pkg::BYTES_PER_CHIP + 1),
    parameter int JOB_W       = 2 * LEN_W + 1 + 2 * CNT_W
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [smq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [smq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire logic [smq_pkg::OP_W-1:0]            opcode,
    input  wire logic [smq_pkg::BYTE_W-1:0]          data_byte,
    output logic                                     ram_we,
    output logic      [$clog2(STORE_DEPTH)-1:0]      ram_waddr,
    output logic      [smq_pkg::BYTE_W-1:0]          ram_wdata,
    output logic                                     job_push,
    output logic      [JOB_W-1:0]                    job_data,
    input  wire logic                                job_full,
    input  wire logic                                job_empty,
    input  wire logic                                back_busy
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CW     = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 1;

    typedef struct packed {
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             cont;
        logic [CNT_W-1:0] numc;
        logic [CNT_W-1:0] span;
    } job_t;

    // configuration
    logic                               scroll_enable_reg;
    logic                               continuous_reg;
    logic [smq_pkg::MS_W-1:0]           start_delay_reg;
    logic [smq_pkg::MS_W-1:0]           end_dwell_reg;
    logic [smq_pkg::MS_W-1:0]           step_period_reg;
    logic [smq_pkg::DIGITS_W-1:0]       shown_digits_reg;
    logic [smq_pkg::CHIPS_W-1:0]        display_count_reg;

    // scroll state
    logic [LEN_W-1:0]                   len_reg;
    logic [LEN_W-1:0]                   len_next;
    logic [LEN_W-1:0]                   prev_reg;
    logic [LEN_W-1:0]                   prev_next;
    logic [LEN_W-1:0]                   off_reg;
    logic [LEN_W-1:0]                   off_next;
    logic [smq_pkg::MS_W-1:0]           ms_reg;
    logic [smq_pkg::MS_W-1:0]           ms_next;

    logic                               fire;
    logic                               cfg_fire;
    logic [smq_pkg::CHIPS_W-1:0]        chips;
    logic [CNT_W-1:0]                   numc;
    logic [CNT_W-1:0]                   half;
    logic [7:0]                         digits;
    logic [CNT_W-1:0]                   span;
    logic [CW-1:0]                      len_w;
    logic [CW-1:0]                      off_w;
    logic [CW-1:0]                      numc_w;
    logic                               long_text;
    logic                               at_end;
    logic [smq_pkg::MS_W-1:0]           ms_inc;
    logic                               tick_emit;
    job_t                               job;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign fire      = cmd_valid && !cmd_stall;

    // appends must not overwrite the store while a window is still read out
    always_comb
    begin
        unique case (opcode) inside
            smq_pkg::OP_TICK, smq_pkg::OP_COMMIT: cmd_stall = job_full;
            smq_pkg::OP_APPEND:                   cmd_stall = !job_empty || back_busy;
            default:                              cmd_stall = 1'b0;
        endcase
    end

    always_comb
    begin
        if (display_count_reg == '0)
        begin
            chips = smq_pkg::CHIPS_W'(1);
        end
        else if (display_count_reg > smq_pkg::CHIPS_W'(MAX_CHIPS))
        begin
            chips = smq_pkg::CHIPS_W'(MAX_CHIPS);
        end
        else
        begin
            chips = display_count_reg;
        end
    end

    assign numc   = CNT_W'(chips) << smq_pkg::BPC_SHIFT;
    assign half   = numc >> 1;
    assign digits = (8'(shown_digits_reg) > 8'(half)) ? 8'(half) : 8'(shown_digits_reg);
    assign span   = CNT_W'(digits << 1);

    assign len_w     = CW'(len_reg);
    assign off_w     = CW'(off_reg);
    assign numc_w    = CW'(numc);
    assign long_text = len_w > numc_w;
    assign at_end    = continuous_reg ? (off_w > len_w - CW'(2))
                                      : (off_w + numc_w >= len_w);
    assign ms_inc    = (ms_reg == '1) ? ms_reg : ms_reg + 1'b1;

    always_comb
    begin
        len_next  = len_reg;
        prev_next = prev_reg;
        off_next  = off_reg;
        ms_next   = ms_reg;
        tick_emit = 1'b0;
        ram_we    = 1'b0;
        if (fire)
        begin
            unique case (opcode)
                smq_pkg::OP_TICK:
                begin
                    ms_next = ms_inc;
                    if (scroll_enable_reg && long_text &&
                        !(off_reg == '0 && ms_inc < start_delay_reg))
                    begin
                        if (at_end)
                        begin
                            if (continuous_reg || ms_inc >= end_dwell_reg)
                            begin
                                off_next  = '0;
                                ms_next   = '0;
                                tick_emit = 1'b1;
                            end
                        end
                        else if (ms_inc >= step_period_reg)
                        begin
                            off_next  = off_reg + LEN_W'(2);
                            ms_next   = '0;
                            tick_emit = 1'b1;
                        end
                    end
                end
                smq_pkg::OP_BEGIN:
                begin
                    prev_next = len_reg;
                    len_next  = '0;
                end
                smq_pkg::OP_APPEND:
                begin
                    // full store drops the byte
                    if (len_reg < LEN_W'(STORE_DEPTH))
                    begin
                        ram_we   = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                smq_pkg::OP_COMMIT:
                begin
                    if ((scroll_enable_reg && prev_reg != len_reg && !continuous_reg) ||
                        !long_text)
                    begin
                        off_next = '0;
                        ms_next  = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ram_waddr = len_reg[ADDR_W-1:0];
    assign ram_wdata = data_byte;

    assign job_push = fire && ((opcode == smq_pkg::OP_COMMIT) ||
                               (opcode == smq_pkg::OP_TICK && tick_emit));

    always_comb
    begin
        job.offset = off_next;
        job.length = len_reg;
        job.cont   = continuous_reg;
        job.numc   = numc;
        job.span   = span;
    end

    assign job_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_enable_reg <= smq_pkg::RST_SCROLL_ENABLE;
            continuous_reg    <= smq_pkg::RST_CONTINUOUS_MODE;
            start_delay_reg   <= smq_pkg::RST_START_DELAY;
            end_dwell_reg     <= smq_pkg::RST_END_DWELL;
            step_period_reg   <= smq_pkg::RST_STEP_PERIOD;
            shown_digits_reg  <= smq_pkg::RST_SHOWN_DIGITS;
            display_count_reg <= smq_pkg::RST_DISPLAY_COUNT;
            len_reg           <= '0;
            prev_reg          <= '0;
            off_reg           <= '0;
            ms_reg            <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            prev_reg <= prev_next;
            off_reg  <= off_next;
            ms_reg   <= ms_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    smq_pkg::REG_SCROLL_ENABLE:   scroll_enable_reg <= cfg_data[0];
                    smq_pkg::REG_CONTINUOUS_MODE: continuous_reg    <= cfg_data[0];
                    smq_pkg::REG_START_DELAY:     start_delay_reg   <= cfg_data;
                    smq_pkg::REG_END_DWELL:       end_dwell_reg     <= cfg_data;
                    smq_pkg::REG_STEP_PERIOD:     step_period_reg   <= cfg_data;
                    smq_pkg::REG_SHOWN_DIGITS:
                        shown_digits_reg <= cfg_data[smq_pkg::DIGITS_W-1:0];
                    smq_pkg::REG_DISPLAY_COUNT:
                        display_count_reg <= cfg_data[smq_pkg::CHIPS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_append_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && opcode == smq_pkg::OP_APPEND) |-> (job_empty && !back_busy))
        else $error("append accepted while the store is being read");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(STORE_DEPTH))
        else $error("text length beyond store depth");

endmodule

`default_nettype wire

[rtl/core/smq_back.sv]
`default_nettype none

module smq_back #(
    parameter int STORE_DEPTH = smq_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHIPS   = smq_pkg::MAX_CHIPS_DEF,
    parameter int LEN_W       = $clog2(STORE_DEPTH + 1),
    parameter int CNT_W       = $clog2(MAX_CHIPS * smq_pkg::BYTES_PER_CHIP + 1),
    parameter int JOB_W       = 2 * LEN_W + 1 + 2 * CNT_W
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [JOB_W-1:0]                job_data,
    input  wire logic                            job_empty,
    output logic                                 job_pop,
    output logic                                 busy,
    output logic                                 ram_re,
    output logic      [$clog2(STORE_DEPTH)-1:0]  ram_raddr,
    input  wire logic [smq_pkg::BYTE_W-1:0]      ram_rdata,
    output logic                                 seg_valid,
    input  wire logic                            seg_stall,
    output logic      [smq_pkg::BYTE_W-1:0]      segment_byte,
    output logic      [smq_pkg::BIDX_W-1:0]      byte_index,
    output logic                                 last_byte
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int IDX_W  = $clog2(MAX_CHIPS * smq_pkg::BYTES_PER_CHIP);
    localparam int STEP_W = $clog2(LEN_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             cont;
        logic [CNT_W-1:0] numc;
        logic [CNT_W-1:0] span;
    } job_t;

    typedef struct packed {
        logic [smq_pkg::BYTE_W-1:0] seg;
        logic [smq_pkg::BIDX_W-1:0] idx;
        logic                       last;
    } word_t;

    job_t              job;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  pos_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              cont_reg;
    logic              cont_next;
    logic [CNT_W-1:0]  numc_reg;
    logic [CNT_W-1:0]  numc_next;
    logic [CNT_W-1:0]  span_reg;
    logic [CNT_W-1:0]  span_next;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  i_next;
    logic [LEN_W-1:0]  dvd_reg;
    logic [LEN_W-1:0]  dvd_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // read in flight: ram data shows up in the cycle after issue
    logic              s1_v_reg;
    logic              s1_use_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_last_reg;

    // two-word output queue, head drives the port
    logic [1:0]        occ_reg;
    logic [1:0]        occ_next;
    word_t             e0_reg;
    word_t             e1_reg;
    word_t             push_word;

    logic              pop;
    logic              room;
    logic              issue;
    logic              use_byte;
    logic              is_last;
    logic [LEN_W-1:0]  pos_plus;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    trial_sub;

    assign job = job_data;

    assign pop  = (occ_reg != 2'd0) && !seg_stall;
    // issue only when the word still in flight plus this one will fit
    assign room = (3'(occ_reg) + 3'(s1_v_reg)) < (3'd2 + 3'(pop));

    assign issue    = (state_reg == ST_RUN) && room;
    assign use_byte = (len_reg != '0) && (CNT_W'(i_reg) < span_reg) && (pos_reg < len_reg);
    assign is_last  = (CNT_W'(i_reg) == numc_reg - 1'b1);
    assign pos_plus = pos_reg + 1'b1;

    assign ram_re    = issue && use_byte;
    assign ram_raddr = pos_reg[ADDR_W-1:0];

    assign busy    = (state_reg != ST_IDLE);
    assign job_pop = (state_reg == ST_IDLE) && !job_empty;

    // restoring remainder, one dividend bit per cycle
    assign trial     = {rem_reg, dvd_reg[LEN_W-1]};
    assign trial_sub = trial - {1'b0, len_reg};

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cont_next  = cont_reg;
        numc_next  = numc_reg;
        span_next  = span_reg;
        i_next     = i_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    len_next  = job.length;
                    cont_next = job.cont;
                    numc_next = job.numc;
                    span_next = job.span;
                    i_next    = '0;
                    // continuous mode starts at offset mod length
                    if (job.cont && job.length != '0 && job.offset >= job.length)
                    begin
                        dvd_next   = job.offset;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        pos_next   = job.offset;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_MOD:
            begin
                if (trial >= {1'b0, len_reg})
                begin
                    rem_next = trial_sub[LEN_W-1:0];
                end
                else
                begin
                    rem_next = trial[LEN_W-1:0];
                end
                dvd_next  = dvd_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LEN_W - 1))
                begin
                    pos_next   = rem_next;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (use_byte)
                    begin
                        if (cont_reg && pos_plus == len_reg)
                        begin
                            pos_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_plus;
                        end
                    end
                    i_next = i_reg + 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_word.seg  = s1_use_reg ? ram_rdata : '0;
        push_word.idx  = smq_pkg::BIDX_W'(s1_idx_reg);
        push_word.last = s1_last_reg;
        occ_next       = occ_reg + 2'(s1_v_reg) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            s1_v_reg  <= 1'b0;
            occ_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= issue;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        cont_reg <= cont_next;
        numc_reg <= numc_next;
        span_reg <= span_next;
        i_reg    <= i_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (issue)
        begin
            s1_use_reg  <= use_byte;
            s1_idx_reg  <= i_reg;
            s1_last_reg <= is_last;
        end
        if (pop && occ_reg == 2'd2)
        begin
            e0_reg <= e1_reg;
        end
        else if (s1_v_reg && (occ_reg == 2'd0 || (occ_reg == 2'd1 && pop)))
        begin
            e0_reg <= push_word;
        end
        if (s1_v_reg && ((occ_reg == 2'd1 && !pop) || (occ_reg == 2'd2 && pop)))
        begin
            e1_reg <= push_word;
        end
    end

    assign seg_valid    = (occ_reg != 2'd0);
    assign segment_byte = e0_reg.seg;
    assign byte_index   = e0_reg.idx;
    assign last_byte    = e0_reg.last;

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("output queue overflow");

    a_read_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> $past(state_reg == ST_RUN))
        else $error("store read issued outside a window burst");

    a_mod_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (len_reg != '0))
        else $error("remainder run on an empty text");

endmodule

`default_nettype wire

[rtl/core/segment_marquee_scroller_top.sv]
// Scrolling marquee for chained 16-segment driver chips.
// cmd channel (cmd_valid/cmd_stall, opcode, data_byte): millisecond tick, begin update,
// append byte, commit. seg channel (seg_valid/seg_stall) returns window words:
// segment_byte, byte_index, last_byte on the final word of a burst.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register per cycle,
// cfg_ready is always high; write only while no window is in flight.
// A commit, or a tick on which the scroll moves, gives one burst of display_count*16 words
// (16 to 64, display_count taken as 1 to MAX_CHIPS). Words leave one per cycle from the store
// read port while the receiver does not stall; the first word follows the command through the
// job queue, store read and output queue, after a remainder run over the offset bits (9 for a
// 256-byte store) when continuous mode must wrap a stale offset. Ticks and commits queue up to
// two pending windows; append stalls while a window is queued or being read from the store.
// When the receiver stalls, words wait in a two-word output queue and store reads pause.
// Reset clears text length, offset and the ms counter and loads register defaults; the
// text store itself is not cleared and only entries written since begin are read.
`default_nettype none

module segment_marquee_scroller_top #(
    parameter int STORE_DEPTH = smq_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHIPS   = smq_pkg::MAX_CHIPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smq_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_stall,
    input  wire logic [smq_pkg::OP_W-1:0]        opcode,
    input  wire logic [smq_pkg::BYTE_W-1:0]      data_byte,
    output logic                                 seg_valid,
    input  wire logic                            seg_stall,
    output logic      [smq_pkg::BYTE_W-1:0]      segment_byte,
    output logic      [smq_pkg::BIDX_W-1:0]      byte_index,
    output logic                                 last_byte
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_CHIPS * smq_pkg::BYTES_PER_CHIP + 1);
    localparam int JOB_W  = 2 * LEN_W + 1 + 2 * CNT_W;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [smq_pkg::BYTE_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [smq_pkg::BYTE_W-1:0]   ram_rdata;

    logic                         job_push;
    logic [JOB_W-1:0]             job_in;
    logic                         job_pop;
    logic [JOB_W-1:0]             job_out;
    logic                         job_full;
    logic                         job_empty;
    logic                         back_busy;

    smq_ram #(
        .WIDTH (smq_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smq_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_CHIPS   (MAX_CHIPS),
        .LEN_W       (LEN_W),
        .CNT_W       (CNT_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .job_push   (job_push),
        .job_data   (job_in),
        .job_full   (job_full),
        .job_empty  (job_empty),
        .back_busy  (back_busy)
    );

    smq_job_fifo #(
        .WIDTH (JOB_W)
    ) u_jobs (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .full      (job_full),
        .empty     (job_empty)
    );

    smq_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_CHIPS   (MAX_CHIPS),
        .LEN_W       (LEN_W),
        .CNT_W       (CNT_W),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_data     (job_out),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .busy         (back_busy),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .segment_byte (segment_byte),
        .byte_index   (byte_index),
        .last_byte    (last_byte)
    );

endmodule

`default_nettype wire
